### hw/rtl/cc20_pkg.sv
// shared types, constants and helper functions of the chacha20 stream cipher core
// no dependencies; imported by cc20_qr_alu, cc20_block_gen and the top level
package cc20_pkg;

   typedef logic [31:0] word_type;
   typedef logic [15:0][31:0] state_type;
   typedef logic [3:0][1:0] row_amt_type;

   // block constant "expand 32-byte k"
   localparam state_type SigmaWords = {
      384'd0,
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   localparam int DoubleRounds = 10;
   localparam int StepsPerQuarter = 4;
   localparam int QuartersPerHalf = 4;
   localparam int RoundSteps = DoubleRounds * 2 * QuartersPerHalf * StepsPerQuarter;
   localparam int RoundCntW = $clog2(RoundSteps);
   localparam logic [RoundCntW-1:0] LastRoundCnt = RoundCntW'(RoundSteps - 1);
   localparam int ByteAddrW = 6;
   localparam logic [ByteAddrW-1:0] LastBytePos = 6'd63;

   // configuration register indexes
   localparam int CsrIndexW = 3;
   localparam logic [CsrIndexW-1:0] CSR_KEY_PART0 = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_KEY_PART1 = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_KEY_PART2 = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_KEY_PART3 = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_NONCE_LOW = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_NONCE_HIGH = 3'd5;
   localparam logic [CsrIndexW-1:0] CSR_START_COUNTER = 3'd6;

   // add-xor-rotate step within a quarter round
   localparam logic [1:0] STEP_ROT16 = 2'd0;
   localparam logic [1:0] STEP_ROT12 = 2'd1;
   localparam logic [1:0] STEP_ROT8 = 2'd2;
   localparam logic [1:0] STEP_ROT7 = 2'd3;

   typedef struct packed {
      logic start;
   } gen_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gen_status_type;

   // rotate each row of the 4x4 word matrix left by its own amount
   function automatic state_type rotate_rows(state_type s, row_amt_type amt);
      state_type res;
      logic [1:0] src;
      res = s;
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) begin
            src = 2'(j) + amt[r];
            res[4*r+j] = s[4*r + int'(src)];
         end
      end
      return res;
   endfunction

endpackage

### hw/rtl/chacha20_stream_cipher_core.sv
// chacha20 stream cipher top level: configuration registers, byte position and item handshake
// depends on cc20_pkg and cc20_block_gen
//
// Each request item is one byte, XORed with the next keystream byte. While a keystream block
// is in hand items are taken back to back unless the response output stalls. A byte that
// needs a new block waits while the block is made: the generator is launched, runs 320
// add-xor-rotate steps on the one shared 32-bit unit (10 double rounds, four steps per
// quarter round), then 16 feed-forward additions on the same adder, and then the byte is
// taken. A byte flagged last drops the rest of its block. Writing start_counter loads the
// block counter; key, nonce and counter take effect at the next block made. The block
// counter wraps at 2^32. Write configuration only while no item is in flight.
module chacha20_stream_cipher_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [cc20_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [63:0]                        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_message_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_cipher_byte,
   output logic                               rsp_out_last
);
   import cc20_pkg::*;

   logic [63:0] key_part0_ff, key_part1_ff, key_part2_ff, key_part3_ff, nonce_low_ff;
   logic [31:0] nonce_high_ff;
   logic [31:0] block_counter_ff, block_counter_in;
   logic [ByteAddrW-1:0] byte_pos_ff, byte_pos_in;
   logic block_ready_ff, block_ready_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] cipher_byte_ff;
   logic out_last_ff;

   state_type init_words;
   state_type keystream;
   gen_ctrl_type gen_ctrl;
   gen_status_type gen_status;
   word_type ks_word;
   logic [7:0] ks_byte;
   logic out_free;
   logic req_accept;

   always_comb begin
      init_words = SigmaWords;
      init_words[4] = key_part0_ff[31:0];
      init_words[5] = key_part0_ff[63:32];
      init_words[6] = key_part1_ff[31:0];
      init_words[7] = key_part1_ff[63:32];
      init_words[8] = key_part2_ff[31:0];
      init_words[9] = key_part2_ff[63:32];
      init_words[10] = key_part3_ff[31:0];
      init_words[11] = key_part3_ff[63:32];
      init_words[12] = block_counter_ff;
      init_words[13] = nonce_low_ff[31:0];
      init_words[14] = nonce_low_ff[63:32];
      init_words[15] = nonce_high_ff;
   end

   assign gen_ctrl.start = req_valid && !block_ready_ff && !gen_status.busy;

   cc20_block_gen u_block_gen (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (gen_ctrl),
      .init_words (init_words),
      .status     (gen_status),
      .keystream  (keystream)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(block_ready_ff && out_free);
   assign req_accept = req_valid && !req_stall;

   assign ks_word = keystream[byte_pos_ff[5:2]];
   assign ks_byte = ks_word[{byte_pos_ff[1:0], 3'b000} +: 8];

   always_comb begin
      block_counter_in = block_counter_ff;
      byte_pos_in = byte_pos_ff;
      block_ready_in = block_ready_ff;
      priority if (csr_write && csr_index == CSR_START_COUNTER) begin
         block_counter_in = csr_wdata[31:0];
      end else if (gen_status.done) begin
         block_counter_in = block_counter_ff + 32'd1;
      end else begin
         block_counter_in = block_counter_ff;
      end
      priority if (gen_status.done) begin
         byte_pos_in = '0;
         block_ready_in = 1'b1;
      end else if (req_accept) begin
         if (req_message_last || byte_pos_ff == LastBytePos) begin
            byte_pos_in = '0;
            block_ready_in = 1'b0;
         end else begin
            byte_pos_in = byte_pos_ff + 1'b1;
         end
      end else begin
         byte_pos_in = byte_pos_ff;
         block_ready_in = block_ready_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_part0_ff <= '0;
         key_part1_ff <= '0;
         key_part2_ff <= '0;
         key_part3_ff <= '0;
         nonce_low_ff <= '0;
         nonce_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_PART0:  key_part0_ff <= csr_wdata;
            CSR_KEY_PART1:  key_part1_ff <= csr_wdata;
            CSR_KEY_PART2:  key_part2_ff <= csr_wdata;
            CSR_KEY_PART3:  key_part3_ff <= csr_wdata;
            CSR_NONCE_LOW:  nonce_low_ff <= csr_wdata;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_counter_ff <= '0;
         byte_pos_ff <= '0;
         block_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         block_counter_ff <= block_counter_in;
         byte_pos_ff <= byte_pos_in;
         block_ready_ff <= block_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cipher_byte_ff <= req_data_byte ^ ks_byte;
         out_last_ff <= req_message_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cipher_byte = cipher_byte_ff;
   assign rsp_out_last = out_last_ff;

`ifndef SYNTHESIS
   a_pos_needs_block: assert property (@(posedge clock) disable iff (reset)
      byte_pos_ff != '0 |-> block_ready_ff)
      else $error("byte position advanced without a keystream block");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      gen_status.busy |-> !block_ready_ff)
      else $error("block generation while a block is still in hand");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      gen_status.done |=> block_ready_ff && byte_pos_ff == '0)
      else $error("finished block not marked ready at byte zero");
`endif

endmodule

### hw/rtl/cc20_qr_alu.sv
// shared add-xor-rotate unit, one quarter-round step per use
// depends on cc20_pkg
module cc20_qr_alu (
   input  cc20_pkg::word_type opa,
   input  cc20_pkg::word_type opb,
   input  cc20_pkg::word_type opc,
   input  logic [1:0]         step,
   output cc20_pkg::word_type sum,
   output cc20_pkg::word_type mix
);
   import cc20_pkg::*;

   word_type mixed;

   assign sum = opa + opb;
   assign mixed = opc ^ sum;

   always_comb begin
      unique case (step)
         STEP_ROT16: mix = {mixed[15:0], mixed[31:16]};
         STEP_ROT12: mix = {mixed[19:0], mixed[31:20]};
         STEP_ROT8:  mix = {mixed[23:0], mixed[31:24]};
         STEP_ROT7:  mix = {mixed[24:0], mixed[31:25]};
         default:    mix = mixed;
      endcase
   end

endmodule

### hw/rtl/cc20_block_gen.sv
// keystream block generator: working state, round sequencer and feed-forward sweep
// depends on cc20_pkg and cc20_qr_alu
module cc20_block_gen (
   input  logic                     clock,
   input  logic                     reset,
   input  cc20_pkg::gen_ctrl_type   ctrl,
   input  cc20_pkg::state_type      init_words,
   output cc20_pkg::gen_status_type status,
   output cc20_pkg::state_type      keystream
);
   import cc20_pkg::*;

   typedef enum logic [2:0] {
      GEN_IDLE  = 3'b001,
      GEN_ROUND = 3'b010,
      GEN_FEED  = 3'b100
   } gen_state_type;

   gen_state_type state_ff, state_in;
   logic [RoundCntW-1:0] cnt_ff, cnt_in;
   state_type work_ff, work_in;
   state_type ks_ff, ks_in;

   logic [1:0] step;
   logic [1:0] quarter;
   logic       diag_half;
   logic       feed_last;
   word_type   opa, opb, opc, sum, mix;
   state_type  work_step;
   row_amt_type rot_amt;

   // counter bits: step, quarter within half round, half round
   assign step = cnt_ff[1:0];
   assign quarter = cnt_ff[3:2];
   assign diag_half = cnt_ff[4];
   assign feed_last = (cnt_ff[3:0] == 4'hf);

   always_comb begin
      priority if (state_ff == GEN_FEED) begin
         opa = work_ff[0];
         opb = init_words[cnt_ff[3:0]];
         opc = work_ff[12];
      end else if (!step[0]) begin
         opa = work_ff[0];
         opb = work_ff[4];
         opc = work_ff[12];
      end else begin
         opa = work_ff[8];
         opb = work_ff[12];
         opc = work_ff[4];
      end
   end

   cc20_qr_alu u_alu (
      .opa  (opa),
      .opb  (opb),
      .opc  (opc),
      .step (step),
      .sum  (sum),
      .mix  (mix)
   );

   // column 0 always holds the active quarter; rows rotate after each quarter,
   // with an extra per-row shift entering and leaving the diagonal half
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         priority if (quarter != 2'd3) begin
            rot_amt[r] = 2'd1;
         end else if (!diag_half) begin
            rot_amt[r] = 2'd1 + 2'(r);
         end else begin
            rot_amt[r] = 2'd1 - 2'(r);
         end
      end
   end

   always_comb begin
      work_step = work_ff;
      if (!step[0]) begin
         work_step[0] = sum;
         work_step[12] = mix;
      end else begin
         work_step[8] = sum;
         work_step[4] = mix;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      work_in = work_ff;
      ks_in = ks_ff;
      unique case (state_ff)
         GEN_IDLE: begin
            if (ctrl.start) begin
               work_in = init_words;
               cnt_in = '0;
               state_in = GEN_ROUND;
            end
         end
         GEN_ROUND: begin
            work_in = (step == STEP_ROT7) ? rotate_rows(work_step, rot_amt) : work_step;
            if (cnt_ff == LastRoundCnt) begin
               cnt_in = '0;
               state_in = GEN_FEED;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         GEN_FEED: begin
            ks_in = {sum, ks_ff[15:1]};
            work_in = {work_ff[0], work_ff[15:1]};
            cnt_in = cnt_ff + 1'b1;
            if (feed_last) begin
               state_in = GEN_IDLE;
            end
         end
         default: begin
            state_in = GEN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      ks_ff <= ks_in;
   end

   assign status.busy = (state_ff != GEN_IDLE);
   assign status.done = (state_ff == GEN_FEED) && feed_last;
   assign keystream = ks_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == GEN_IDLE)
      else $error("block start while generator busy");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == GEN_ROUND |-> cnt_ff <= LastRoundCnt)
      else $error("round counter past last step");

   a_feed_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == GEN_FEED |-> cnt_ff[RoundCntW-1:4] == '0)
      else $error("feed-forward counter out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      status.done |=> state_ff == GEN_IDLE)
      else $error("generator not idle after block done");
`endif

endmodule
